>>> rtl/kntf_pkg.sv
`timescale 1ns / 1ps

package kntf_pkg;

    localparam int TABLE_ENTRIES = 48;
    localparam int SLOT_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int WORD_W        = 64;
    localparam int ROW_W         = 4 * WORD_W;
    localparam int ROW_BYTES     = ROW_W / 8;

    localparam logic [1:0] REQ_REMEMBER = 2'd0;
    localparam logic [1:0] REQ_LOOKUP   = 2'd1;
    localparam logic [1:0] REQ_WIPE     = 2'd2;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [WORD_W-1:0] key_word_0;
        logic [WORD_W-1:0] key_word_1;
        logic [WORD_W-1:0] key_word_2;
        logic [WORD_W-1:0] key_word_3;
        logic [WORD_W-1:0] name_word_0;
        logic [WORD_W-1:0] name_word_1;
        logic [WORD_W-1:0] name_word_2;
        logic [WORD_W-1:0] name_word_3;
    } t_in_item;

    typedef struct packed {
        logic              found;
        logic              changed;
        logic [WORD_W-1:0] out_name_0;
        logic [WORD_W-1:0] out_name_1;
        logic [WORD_W-1:0] out_name_2;
        logic [WORD_W-1:0] out_name_3;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;         // capture the input beat, clear the result
        logic scan_clr;     // rewind the scan pointer
        logic scan_step;    // read the row at the scan pointer, advance
        logic wr_hit;       // rename the entry that just matched
        logic wr_new;       // append, or replace the oldest entry
        logic res_found;    // mark lookup hit, take the matched name
        logic res_changed;  // mark the table as changed
        logic wipe;         // empty the table
        logic out_load;     // move the result into the output register
    } t_cmd;

    typedef struct packed {
        logic [1:0] req;
        logic       key_ok;
        logic       name_ok;
        logic       hit;
        logic       name_same;
        logic       more;
        logic       out_free;
    } t_status;

    // True when no byte of the key is zero.
    function automatic logic key_is_valid(input logic [ROW_W-1:0] k);
        logic ok;
        ok = 1'b1;
        for (int b = 0; b < ROW_BYTES; b++) begin
            if (k[b*8 +: 8] == 8'd0) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    // Clear every byte after the first zero byte; byte 0 sits at the top.
    function automatic logic [ROW_W-1:0] name_normalize(input logic [ROW_W-1:0] n);
        logic [ROW_W-1:0] res;
        logic             live;
        res  = '0;
        live = 1'b1;
        for (int b = ROW_BYTES - 1; b >= 0; b--) begin
            if (n[b*8 +: 8] == 8'd0) begin
                live = 1'b0;
            end
            if (live) begin
                res[b*8 +: 8] = n[b*8 +: 8];
            end
        end
        return res;
    endfunction

endpackage

>>> rtl/kntf_ctrl.sv
`timescale 1ns / 1ps

module kntf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  kntf_pkg::t_status i_status,
    output kntf_pkg::t_cmd    o_cmd
);
    import kntf_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if ((i_status.req == REQ_REMEMBER && i_status.key_ok && i_status.name_ok) ||
                    (i_status.req == REQ_LOOKUP && i_status.key_ok)) begin
                    o_cmd.scan_clr = 1'b1;
                    n_state        = ST_SCAN;
                end else begin
                    o_cmd.wipe = (i_status.req == REQ_WIPE);
                    n_state    = ST_DONE;
                end
            end
            ST_SCAN: begin
                if (i_status.hit) begin
                    if (i_status.req == REQ_REMEMBER) begin
                        o_cmd.wr_hit      = !i_status.name_same;
                        o_cmd.res_changed = !i_status.name_same;
                    end else begin
                        o_cmd.res_found = 1'b1;
                    end
                    n_state = ST_DONE;
                end else if (i_status.more) begin
                    o_cmd.scan_step = 1'b1;
                end else begin
                    if (i_status.req == REQ_REMEMBER) begin
                        o_cmd.wr_new      = 1'b1;
                        o_cmd.res_changed = 1'b1;
                    end
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/kntf_dp.sv
`timescale 1ns / 1ps

module kntf_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kntf_pkg::t_in_item  i_in_data,
    input  kntf_pkg::t_cmd      i_cmd,
    output kntf_pkg::t_status   o_status,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output kntf_pkg::t_out_item o_out_data
);
    import kntf_pkg::*;

    logic [ROW_W-1:0] r_key_mem  [TABLE_ENTRIES];
    logic [ROW_W-1:0] r_name_mem [TABLE_ENTRIES];

    logic [1:0]       r_req;
    logic [ROW_W-1:0] r_key;
    logic [ROW_W-1:0] r_name;
    logic             r_key_ok;
    logic             r_name_ok;

    logic [CNT_W-1:0]  r_count;
    logic [SLOT_W-1:0] r_oldest;
    logic [CNT_W-1:0]  r_idx;

    logic              r_rd_vld;
    logic [SLOT_W-1:0] r_rd_slot;
    logic [ROW_W-1:0]  r_key_q;
    logic [ROW_W-1:0]  r_name_q;

    logic             r_res_found;
    logic             r_res_changed;
    logic [ROW_W-1:0] r_res_name;

    logic      r_out_vld;
    t_out_item r_out;

    logic [ROW_W-1:0]  in_key;
    logic [ROW_W-1:0]  in_name;
    logic              full;
    logic [SLOT_W-1:0] new_slot;
    logic [SLOT_W-1:0] wr_slot;

    assign in_key  = {i_in_data.key_word_0, i_in_data.key_word_1,
                      i_in_data.key_word_2, i_in_data.key_word_3};
    assign in_name = {i_in_data.name_word_0, i_in_data.name_word_1,
                      i_in_data.name_word_2, i_in_data.name_word_3};

    assign full     = (r_count == CNT_W'(TABLE_ENTRIES));
    assign new_slot = full ? r_oldest : r_count[SLOT_W-1:0];
    assign wr_slot  = i_cmd.wr_new ? new_slot : r_rd_slot;

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req     <= i_in_data.req_type;
            r_key     <= in_key;
            r_name    <= name_normalize(in_name);
            r_key_ok  <= key_is_valid(in_key);
            r_name_ok <= (in_name[ROW_W-1 -: 8] != 8'd0);
        end
    end

    // Table memories: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_new) begin
            r_key_mem[wr_slot] <= r_key;
        end
        if (i_cmd.wr_new || i_cmd.wr_hit) begin
            r_name_mem[wr_slot] <= r_name;
        end
        if (i_cmd.scan_step) begin
            r_key_q   <= r_key_mem[r_idx[SLOT_W-1:0]];
            r_name_q  <= r_name_mem[r_idx[SLOT_W-1:0]];
            r_rd_slot <= r_idx[SLOT_W-1:0];
        end
    end

    // Occupancy, replacement pointer and scan pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_oldest <= '0;
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan_step;
            if (i_cmd.scan_clr) begin
                r_idx <= '0;
            end else if (i_cmd.scan_step) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (i_cmd.wipe) begin
                r_count  <= '0;
                r_oldest <= '0;
            end else if (i_cmd.wr_new) begin
                if (!full) begin
                    r_count <= r_count + CNT_W'(1);
                end else if (r_oldest == SLOT_W'(TABLE_ENTRIES - 1)) begin
                    r_oldest <= '0;
                end else begin
                    r_oldest <= r_oldest + SLOT_W'(1);
                end
            end
        end
    end

    // Result being built
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_res_found   <= 1'b0;
            r_res_changed <= 1'b0;
            r_res_name    <= '0;
        end else begin
            if (i_cmd.res_found) begin
                r_res_found <= 1'b1;
                r_res_name  <= r_name_q;
            end
            if (i_cmd.res_changed) begin
                r_res_changed <= 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.found      <= r_res_found;
            r_out.changed    <= r_res_changed;
            r_out.out_name_0 <= r_res_name[ROW_W-1 -: WORD_W];
            r_out.out_name_1 <= r_res_name[ROW_W-WORD_W-1 -: WORD_W];
            r_out.out_name_2 <= r_res_name[ROW_W-2*WORD_W-1 -: WORD_W];
            r_out.out_name_3 <= r_res_name[WORD_W-1:0];
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    assign o_status.req       = r_req;
    assign o_status.key_ok    = r_key_ok;
    assign o_status.name_ok   = r_name_ok;
    assign o_status.hit       = r_rd_vld && (r_key_q == r_key);
    assign o_status.name_same = (r_name_q == r_name);
    assign o_status.more      = (r_idx != r_count);
    assign o_status.out_free  = !r_out_vld || !i_out_stall;

endmodule

>>> rtl/key_name_table_fifo_replace_core.sv
`timescale 1ns / 1ps

// Key-to-name table, 48 entries, first-in first-out replacement.
// Input channel: i_in_valid / o_in_stall with one request beat in i_in_data
// (remember, lookup or wipe, a 32-character key and a 32-byte name).
// Output channel: o_out_valid / i_out_stall, exactly one result beat per
// request (found, changed, stored name).
// One request is in flight at a time. A remember or lookup scans the stored
// entries one per cycle through the registered read port of the table
// memory, so the scan length is at most the number of valid entries N. The
// next beat is accepted once the result has moved into the output register.
// A stalled result holds in the output register; the block still finishes
// the next request and waits in its final state until the register frees.
// Reset empties the table at once (entry count and replacement pointer
// clear, memory contents are left as they are) and drops any pending beat.
module key_name_table_fifo_replace_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  kntf_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output kntf_pkg::t_out_item o_out_data
);
    import kntf_pkg::*;

    // Command and status between sequencer and table datapath
    t_cmd    cmd;
    t_status status;

    kntf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    kntf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

>>> test/key_name_table_fifo_replace_core_test.sv
`timescale 1ns / 1ps

// Checks the key-to-name table against a behavioral table kept here: every
// request beat is predicted on acceptance, and every result beat is compared
// field by field with the oldest prediction still waiting.
module key_name_table_fifo_replace_core_test;
    import kntf_pkg::*;

    // Request code that the block must treat as a no-op.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int POOL_KEYS   = 72;      // more keys than slots, so misses evict
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 64;      // longer than a full-table scan
    localparam int REPORT_MAX  = 10;
    localparam int GAP_MAX     = 60;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    // Shadow of the table: keys, trimmed names, fill level, replacement pointer.
    logic [ROW_W-1:0] tbl_key  [TABLE_ENTRIES];
    logic [ROW_W-1:0] tbl_name [TABLE_ENTRIES];
    int               tbl_count  = 0;
    int               tbl_oldest = 0;

    // Predicted result beats, oldest first.
    t_out_item        reply_q [$];

    // Keys that the random traffic draws from, so hits and evictions both occur.
    logic [ROW_W-1:0] key_pool [POOL_KEYS];

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int cycle_count  = 0;
    int mismatches   = 0;
    int n_sent       = 0;
    int n_checked    = 0;
    int n_remember   = 0;
    int n_changed    = 0;
    int n_evict      = 0;
    int n_lookup     = 0;
    int n_hit        = 0;
    int n_wipe       = 0;
    int n_ignored    = 0;

    key_name_table_fifo_replace_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------------

    // A key is usable only when none of its 32 characters is zero.
    function automatic logic key_all_nonzero(input logic [ROW_W-1:0] k);
        for (int b = 0; b < 32; b++) begin
            if (k[b*8 +: 8] == 8'd0) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Cut the name at its first zero byte; byte 0 is the top byte.
    function automatic logic [ROW_W-1:0] trim_name(input logic [ROW_W-1:0] n);
        logic [ROW_W-1:0] t;
        logic             ended;
        t     = '0;
        ended = 1'b0;
        for (int b = 0; b < 32; b++) begin
            if (n[ROW_W-1-8*b -: 8] == 8'd0) begin
                ended = 1'b1;
            end
            if (!ended) begin
                t[ROW_W-1-8*b -: 8] = n[ROW_W-1-8*b -: 8];
            end
        end
        return t;
    endfunction

    // First valid slot holding the key, or -1.
    function automatic int find_entry(input logic [ROW_W-1:0] k);
        for (int s = 0; s < tbl_count; s++) begin
            if (tbl_key[s] === k) begin
                return s;
            end
        end
        return -1;
    endfunction

    // Apply one request to the shadow table and return the result it must give.
    function automatic t_out_item predict_reply(input t_in_item it);
        t_out_item        r;
        logic [ROW_W-1:0] k;
        logic [ROW_W-1:0] n;
        int               s;
        int               slot;
        r = '0;
        k = {it.key_word_0, it.key_word_1, it.key_word_2, it.key_word_3};
        n = trim_name({it.name_word_0, it.name_word_1, it.name_word_2, it.name_word_3});
        case (it.req_type)
            REQ_REMEMBER: begin
                // Drop a bad key or an empty name without touching the table.
                if (!key_all_nonzero(k) || n[ROW_W-1 -: 8] == 8'd0) begin
                    n_ignored++;
                end else begin
                    n_remember++;
                    s = find_entry(k);
                    if (s < 0) begin
                        // Append while there is room, else overwrite the oldest slot.
                        if (tbl_count < TABLE_ENTRIES) begin
                            slot = tbl_count;
                            tbl_count++;
                        end else begin
                            slot       = tbl_oldest;
                            tbl_oldest = (tbl_oldest + 1) % TABLE_ENTRIES;
                            n_evict++;
                        end
                        tbl_key[slot]  = k;
                        tbl_name[slot] = n;
                        r.changed      = 1'b1;
                    end else if (tbl_name[s] !== n) begin
                        tbl_name[s] = n;
                        r.changed   = 1'b1;
                    end
                end
            end
            REQ_LOOKUP: begin
                if (!key_all_nonzero(k)) begin
                    n_ignored++;
                end else begin
                    n_lookup++;
                    s = find_entry(k);
                    if (s >= 0) begin
                        r.found = 1'b1;
                        {r.out_name_0, r.out_name_1, r.out_name_2, r.out_name_3} = tbl_name[s];
                        n_hit++;
                    end
                end
            end
            REQ_WIPE: begin
                tbl_count  = 0;
                tbl_oldest = 0;
                n_wipe++;
            end
            default: begin
                n_ignored++;
            end
        endcase
        if (r.changed) begin
            n_changed++;
        end
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------

    function automatic logic [ROW_W-1:0] rand_key();
        logic [ROW_W-1:0] k;
        for (int b = 0; b < 32; b++) begin
            k[b*8 +: 8] = 8'($urandom_range(1, 255));
        end
        return k;
    endfunction

    // Random name of 1 to 32 bytes, sometimes with junk after the terminator.
    function automatic logic [ROW_W-1:0] rand_name();
        logic [ROW_W-1:0] n;
        int               len;
        n   = '0;
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 12);
        for (int b = 0; b < len; b++) begin
            n[ROW_W-1-8*b -: 8] = 8'($urandom_range(1, 255));
        end
        if (len < 31 && $urandom_range(0, 3) == 0) begin
            for (int b = len + 1; b < 32; b++) begin
                n[ROW_W-1-8*b -: 8] = 8'($urandom_range(0, 255));
            end
        end
        return n;
    endfunction

    // Same name, with random bytes filled in past its terminator.
    function automatic logic [ROW_W-1:0] with_tail(input logic [ROW_W-1:0] n);
        logic [ROW_W-1:0] t;
        int               len;
        t   = n;
        len = 0;
        while (len < 32 && n[ROW_W-1-8*len -: 8] != 8'd0) begin
            len++;
        end
        for (int b = len + 1; b < 32; b++) begin
            t[ROW_W-1-8*b -: 8] = 8'($urandom_range(0, 255));
        end
        return t;
    endfunction

    function automatic t_in_item make_item(input logic [1:0] req,
                                           input logic [ROW_W-1:0] k,
                                           input logic [ROW_W-1:0] n);
        t_in_item it;
        it.req_type = req;
        {it.key_word_0, it.key_word_1, it.key_word_2, it.key_word_3}     = k;
        {it.name_word_0, it.name_word_1, it.name_word_2, it.name_word_3} = n;
        return it;
    endfunction

    // Mostly well-formed remember/lookup traffic on the key pool; the rest is
    // bad keys, empty names, the unused code, wipes and fresh keys.
    function automatic t_in_item random_request();
        logic [ROW_W-1:0] k;
        logic [ROW_W-1:0] n;
        int               r;
        int               p;
        int               s;
        int               pos;
        r   = $urandom_range(0, 99);
        p   = $urandom_range(0, POOL_KEYS - 1);
        pos = $urandom_range(0, 31);
        k   = key_pool[p];
        n   = rand_name();
        if (r < 45) begin
            // Reuse the stored name now and then, so unchanged remembers occur.
            s = find_entry(k);
            if (s >= 0 && $urandom_range(0, 2) == 0) begin
                n = $urandom_range(0, 1) ? tbl_name[s] : with_tail(tbl_name[s]);
            end
            return make_item(REQ_REMEMBER, k, n);
        end else if (r < 80) begin
            // Now and then alter one character so the key almost matches.
            if ($urandom_range(0, 6) == 0) begin
                k[ROW_W-1-8*pos -: 8] = 8'($urandom_range(1, 255));
            end
            return make_item(REQ_LOOKUP, k, n);
        end else if (r < 86) begin
            if ($urandom_range(0, 1)) begin
                k[ROW_W-1-8*pos -: 8] = 8'd0;
            end else begin
                n[ROW_W-1 -: 8] = 8'd0;
            end
            return make_item(REQ_REMEMBER, k, n);
        end else if (r < 91) begin
            k[ROW_W-1-8*pos -: 8] = 8'd0;
            return make_item(REQ_LOOKUP, k, n);
        end else if (r < 95) begin
            return make_item(REQ_UNUSED, k, n);
        end else if (r < 96) begin
            return make_item(REQ_WIPE, k, n);
        end
        // Retire a pool key in favor of a fresh one.
        key_pool[p] = rand_key();
        return make_item(REQ_REMEMBER, key_pool[p], n);
    endfunction

    // ---------------------------------------------------------------------
    // Request side: one beat per call, idle gaps drawn per beat
    // ---------------------------------------------------------------------

    task automatic send_req(input t_in_item it);
        int gap;
        gap = 0;
        while (gap < GAP_MAX && $urandom_range(0, 99) < tx_idle_pct) begin
            gap++;
        end
        // Drop valid only when a gap follows; otherwise hold it high into the next beat.
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        reply_q.push_back(predict_reply(it));
        n_sent++;
    endtask

    // Hold off the request side until every predicted result has arrived.
    task automatic wait_all_replies();
        i_in_valid <= 1'b0;
        while (reply_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // ---------------------------------------------------------------------
    // Result side: compare accepted beats, draw the stall for the next cycle
    // ---------------------------------------------------------------------

    task automatic note_field(input string what, input logic [63:0] want,
                              input logic [63:0] got);
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
            $display("[%0t] result %0d %s: expected %h, got %h",
                     $time, n_checked, what, want, got);
        end
    endtask

    task automatic check_reply(input t_out_item got);
        t_out_item want;
        if (reply_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
                $display("[%0t] result with nothing pending: found %b changed %b name %h",
                         $time, got.found, got.changed,
                         {got.out_name_0, got.out_name_1, got.out_name_2, got.out_name_3});
            end
        end else begin
            want = reply_q.pop_front();
            if (got.found !== want.found) begin
                note_field("found", want.found, got.found);
            end
            if (got.changed !== want.changed) begin
                note_field("changed", want.changed, got.changed);
            end
            if (got.out_name_0 !== want.out_name_0) begin
                note_field("out_name_0", want.out_name_0, got.out_name_0);
            end
            if (got.out_name_1 !== want.out_name_1) begin
                note_field("out_name_1", want.out_name_1, got.out_name_1);
            end
            if (got.out_name_2 !== want.out_name_2) begin
                note_field("out_name_2", want.out_name_2, got.out_name_2);
            end
            if (got.out_name_3 !== want.out_name_3) begin
                note_field("out_name_3", want.out_name_3, got.out_name_3);
            end
        end
        n_checked++;
    endtask

    // Sample before the edge's updates land, then drive the stall for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            check_reply(o_out_data);
        end
        i_out_stall <= (rx_stall_pct != 0) && ($urandom_range(0, 99) < rx_stall_pct);
    end

    // Stop a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     reply_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Empty-table miss, insert, same name, rename, extreme keys and names,
    // bad keys, empty names, the unused code, near misses and wipe.
    task automatic test_directed();
        logic [ROW_W-1:0] k0;
        logic [ROW_W-1:0] k1;
        logic [ROW_W-1:0] k_bad;
        logic [ROW_W-1:0] n0;
        logic [ROW_W-1:0] n1;
        logic [ROW_W-1:0] ones;
        logic [ROW_W-1:0] junk;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        k0   = rand_key();
        k1   = rand_key();
        n0   = trim_name(rand_name());
        n1   = trim_name(rand_name());
        while (n1 === n0) begin
            n1 = trim_name(rand_name());
        end
        ones = {32{8'h01}};
        send_req(make_item(REQ_LOOKUP, k0, '0));
        send_req(make_item(REQ_REMEMBER, k0, n0));
        send_req(make_item(REQ_LOOKUP, k0, rand_name()));
        send_req(make_item(REQ_REMEMBER, k0, n0));
        send_req(make_item(REQ_REMEMBER, k0, with_tail(n0)));
        send_req(make_item(REQ_REMEMBER, k0, n1));
        send_req(make_item(REQ_LOOKUP, k0, '0));
        send_req(make_item(REQ_REMEMBER, {ROW_W{1'b1}}, {ROW_W{1'b1}}));
        send_req(make_item(REQ_LOOKUP, {ROW_W{1'b1}}, '0));
        send_req(make_item(REQ_REMEMBER, ones, {8'h01, {(ROW_W-8){1'b0}}}));
        send_req(make_item(REQ_LOOKUP, ones, '0));
        // Zero in the last character, then in the first.
        k_bad       = k0;
        k_bad[7:0]  = 8'd0;
        send_req(make_item(REQ_REMEMBER, k_bad, n0));
        k_bad                = k0;
        k_bad[ROW_W-1 -: 8]  = 8'd0;
        send_req(make_item(REQ_LOOKUP, k_bad, '0));
        send_req(make_item(REQ_REMEMBER, '0, '0));
        // Empty name with junk behind the terminator.
        junk                = rand_key();
        junk[ROW_W-1 -: 8]  = 8'd0;
        send_req(make_item(REQ_REMEMBER, k1, junk));
        send_req(make_item(REQ_LOOKUP, k1, '0));
        send_req(make_item(REQ_UNUSED, k0, n0));
        k_bad = k0 ^ {{(ROW_W-8){1'b0}}, 8'h01};
        send_req(make_item(REQ_LOOKUP, k_bad, '0));
        send_req(make_item(REQ_WIPE, k0, n0));
        send_req(make_item(REQ_LOOKUP, k0, '0));
        send_req(make_item(REQ_REMEMBER, k0, n0));
        send_req(make_item(REQ_LOOKUP, k0, '0));
        wait_all_replies();
    endtask

    // Fill the table past capacity so the replacement pointer wraps, then
    // probe evicted and surviving keys; seed the key pool from the tail.
    task automatic test_fifo_replacement();
        logic [ROW_W-1:0] fresh [100];
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_req(make_item(REQ_WIPE, '0, '0));
        for (int i = 0; i < 100; i++) begin
            fresh[i] = rand_key();
            send_req(make_item(REQ_REMEMBER, fresh[i], rand_name()));
        end
        for (int j = 0; j < 16; j++) begin
            send_req(make_item(REQ_LOOKUP, fresh[$urandom_range(0, 99)], '0));
        end
        send_req(make_item(REQ_REMEMBER, fresh[99], rand_name()));
        for (int i = 0; i < POOL_KEYS; i++) begin
            key_pool[i] = fresh[28 + i];
        end
        wait_all_replies();
    endtask

    task automatic test_random_traffic(input int count, input int tx_pct, input int rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        repeat (count) begin
            send_req(random_request());
        end
        wait_all_replies();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_fifo_replacement();
        test_random_traffic(85, 0, 0);
        test_random_traffic(85, 80, 0);
        test_random_traffic(85, 0, 80);
        test_random_traffic(85, 20, 20);

        // Let any stray result show up before judging.
        wait_all_replies();
        rx_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d requests: %0d remembers (%0d changed, %0d evictions),",
                 n_sent, n_remember, n_changed, n_evict);
        $display("%0d lookups (%0d hits), %0d wipes, %0d ignored requests,",
                 n_lookup, n_hit, n_wipe, n_ignored);
        $display("%0d results checked, %0d mismatches", n_checked, mismatches);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/kntf_pkg.sv
rtl/kntf_ctrl.sv
rtl/kntf_dp.sv
rtl/key_name_table_fifo_replace_core.sv
test/key_name_table_fifo_replace_core_test.sv
